// ===== hdl/art_pkg.sv =====
//------------------------------------------------------------------------------
// art_pkg
// shared types and codes for the allocation range table
//------------------------------------------------------------------------------
`default_nettype none

package art_pkg;

	localparam int OP_BITS     = 2;
	localparam int FIELD_ADDR  = 40;
	localparam int FIELD_LEN   = 32;
	localparam int STATUS_BITS = 2;

	localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_BITS-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_ILLEGAL = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the item, restart the sweep
		logic scan;    // read one table entry
		logic finish;  // commit the table update and register the result
	} art_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;    // read index is at the last entry
	} art_sts_t;

endpackage

`default_nettype wire

// ===== hdl/art_ctrl.sv =====
//------------------------------------------------------------------------------
// art_ctrl
// sequencer: idle, sweep over the table, drain the read stage, finish
//------------------------------------------------------------------------------
`default_nettype none

module art_ctrl
	import art_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output art_cmd_t      cmd,
	input  wire art_sts_t sts
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_finish_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_FINISH)
		else $error("finish did not follow drain");

	a_scan_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_SCAN && busy)
		else $error("accepted item did not start a sweep");

	a_idle_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("controller stayed busy after finish");

endmodule

`default_nettype wire

// ===== hdl/art_dp.sv =====
//------------------------------------------------------------------------------
// art_dp
// range table storage, per-entry compare unit and result register
//------------------------------------------------------------------------------
`default_nettype none

module art_dp
	import art_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDR_BITS     = 40
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire art_cmd_t               cmd,
	output art_sts_t                    sts,
	input  wire logic                   enable,
	input  wire logic [OP_BITS-1:0]     op,
	input  wire logic [FIELD_ADDR-1:0]  address,
	input  wire logic [FIELD_LEN-1:0]   length,
	output logic                        done,
	output logic [STATUS_BITS-1:0]      status,
	output logic                        hit,
	output logic [FIELD_ADDR-1:0]       range_base,
	output logic [FIELD_LEN-1:0]        range_length
);

	localparam int AW = (ADDR_BITS < FIELD_ADDR) ? ADDR_BITS : FIELD_ADDR;
	localparam int CW = (AW > FIELD_LEN) ? AW : FIELD_LEN;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int EW = AW + FIELD_LEN;

	// captured item
	logic [OP_BITS-1:0]   op_q;
	logic [AW-1:0]        addr_q;
	logic [FIELD_LEN-1:0] len_in_q;

	// table
	logic [EW-1:0]            mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// read stage
	logic [IW-1:0] rd_idx_q;
	logic [EW-1:0] rd_data_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic          eval_s1;

	// sweep findings
	logic                 clash_q;
	logic                 slot_found_q;
	logic [IW-1:0]        slot_q;
	logic                 match_q;
	logic [IW-1:0]        match_idx_q;
	logic [AW-1:0]        match_base_q;
	logic [FIELD_LEN-1:0] match_len_q;

	// result register
	logic                   done_q;
	logic [STATUS_BITS-1:0] res_status_q;
	logic                   res_hit_q;
	logic [FIELD_ADDR-1:0]  res_base_q;
	logic [FIELD_LEN-1:0]   res_len_q;

	logic [AW-1:0]        ent_base;
	logic [FIELD_LEN-1:0] ent_len;
	logic                 a_ge_b;
	logic [AW-1:0]        diff_ab;
	logic [AW-1:0]        diff_ba;
	logic [FIELD_LEN-1:0] ent_span;
	logic [FIELD_LEN-1:0] new_span;
	logic                 overlap;
	logic                 holds;
	logic                 cond;

	assign sts.last = (rd_idx_q == IW'(TABLE_ENTRIES - 1));

	// one entry compared per cycle, without wrap past the address space
	assign ent_base = rd_data_s1[EW-1:FIELD_LEN];
	assign ent_len  = rd_data_s1[FIELD_LEN-1:0];
	assign a_ge_b   = (addr_q >= ent_base);
	assign diff_ab  = addr_q - ent_base;
	assign diff_ba  = ent_base - addr_q;
	assign ent_span = (ent_len == '0) ? FIELD_LEN'(1) : ent_len;
	assign new_span = (len_in_q == '0) ? FIELD_LEN'(1) : len_in_q;
	assign overlap  = a_ge_b ? (CW'(diff_ab) < CW'(ent_span))
	                         : (CW'(diff_ba) < CW'(new_span));
	assign holds    = (ent_len == '0) ? (addr_q == ent_base)
	                                  : (a_ge_b && (CW'(diff_ab) < CW'(ent_len)));

	always_comb begin
		case (op_q)
			OP_FREE:  cond = (addr_q == ent_base);
			OP_QUERY: cond = holds;
			default:  cond = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			addr_q   <= address[AW-1:0];
			len_in_q <= length;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_data_s1 <= mem_q[rd_idx_q];
		end
		if (cmd.finish && enable && op_q == OP_ALLOC && !clash_q && slot_found_q) begin
			mem_q[slot_q] <= {addr_q, len_in_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			idx_s1 <= rd_idx_q;
			vld_s1 <= valid_q[rd_idx_q];
		end
		if (eval_s1) begin
			if (!vld_s1 && !slot_found_q) begin
				slot_q <= idx_s1;
			end
			if (vld_s1 && cond && !match_q) begin
				match_idx_q  <= idx_s1;
				match_base_q <= ent_base;
				match_len_q  <= ent_len;
			end
		end
		if (cmd.finish) begin
			res_status_q <= ST_OK;
			res_hit_q    <= 1'b0;
			res_base_q   <= '0;
			res_len_q    <= '0;
			if (enable) begin
				case (op_q)
					OP_ALLOC: begin
						if (clash_q) begin
							res_status_q <= ST_OVERLAP;
						end else if (!slot_found_q) begin
							res_status_q <= ST_FULL;
						end
					end
					OP_FREE: begin
						if (match_q) begin
							res_hit_q  <= 1'b1;
							res_base_q <= FIELD_ADDR'(match_base_q);
							res_len_q  <= match_len_q;
						end else begin
							res_status_q <= ST_ILLEGAL;
						end
					end
					OP_QUERY: begin
						if (match_q) begin
							res_hit_q  <= 1'b1;
							res_base_q <= FIELD_ADDR'(match_base_q);
							res_len_q  <= match_len_q;
						end
					end
					default: begin
						res_status_q <= ST_OK;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rd_idx_q     <= '0;
			eval_s1      <= 1'b0;
			clash_q      <= 1'b0;
			slot_found_q <= 1'b0;
			match_q      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan;
			done_q  <= cmd.finish;
			if (cmd.load) begin
				rd_idx_q     <= '0;
				clash_q      <= 1'b0;
				slot_found_q <= 1'b0;
				match_q      <= 1'b0;
			end else if (cmd.scan && !sts.last) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (eval_s1) begin
				if (!vld_s1) begin
					slot_found_q <= 1'b1;
				end
				if (vld_s1 && overlap) begin
					clash_q <= 1'b1;
				end
				if (vld_s1 && cond) begin
					match_q <= 1'b1;
				end
			end
			if (cmd.finish && enable) begin
				if (op_q == OP_ALLOC && !clash_q && slot_found_q) begin
					valid_q[slot_q] <= 1'b1;
				end else if (op_q == OP_FREE && match_q) begin
					valid_q[match_idx_q] <= 1'b0;
				end
			end
		end
	end

	assign done         = done_q;
	assign status       = res_status_q;
	assign hit          = res_hit_q;
	assign range_base   = res_base_q;
	assign range_length = res_len_q;

	a_hit_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> status == ST_OK)
		else $error("hit reported with an error status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> range_base == '0 && range_length == '0)
		else $error("miss carries nonzero range fields");

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit && op_q == OP_FREE |->
		$countones(valid_q) + 1 == $countones($past(valid_q)))
		else $error("free hit did not remove exactly one entry");

	a_alloc_adds: assert property (@(posedge clk) disable iff (!arst_n)
		done && op_q == OP_ALLOC && status == ST_OK && $past(enable) |->
		$countones(valid_q) == $countones($past(valid_q)) + 1)
		else $error("accepted allocation did not add exactly one entry");

endmodule

`default_nettype wire

// ===== hdl/allocation_range_table_top.sv =====
//------------------------------------------------------------------------------
// allocation_range_table_top
// table of allocated device address ranges: record, free and look up
//------------------------------------------------------------------------------
// channel   | handshake              | payload
// item in   | start & !busy          | op, address, length
// result    | done (one cycle)       | status, hit, range_base, range_length
// config    | cfg_valid & cfg_ready  | cfg_data (recording_enable)
//
// done rises in the same cycle that busy falls. the sweep reads one table entry
// per cycle from the single read port and compares it.
// reset clears all entry valid bits and recording_enable; no clearing pass.
// done is held for exactly one cycle and cannot be stalled; a new item may be
// started in the cycle that done is high.
//------------------------------------------------------------------------------
`default_nettype none

module allocation_range_table_top
	import art_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDR_BITS     = 40
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [OP_BITS-1:0]     op,
	input  wire logic [FIELD_ADDR-1:0]  address,
	input  wire logic [FIELD_LEN-1:0]   length,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	output logic                        done,
	output logic [STATUS_BITS-1:0]      status,
	output logic                        hit,
	output logic [FIELD_ADDR-1:0]       range_base,
	output logic [FIELD_LEN-1:0]        range_length
);

	art_cmd_t cmd;
	art_sts_t sts;
	logic     enable_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	art_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	art_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDR_BITS     (ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.enable       (enable_q),
		.op           (op),
		.address      (address),
		.length       (length),
		.done         (done),
		.status       (status),
		.hit          (hit),
		.range_base   (range_base),
		.range_length (range_length)
	);

endmodule

`default_nettype wire
